### sv/pmi_pkg.sv
// Shared types, constants and the saturating helper function of the particle motion integrator.
package pmi_pkg;

	localparam int AXES      = 3;
	localparam int DATA_W    = 32;
	localparam int DT_W      = 16;
	localparam int CFG_IDX_W = 4;

	typedef logic signed [DATA_W-1:0] q16_t;
	typedef logic [DATA_W-1:0]        uq16_t;
	typedef logic [DT_W-1:0]          dt_t;
	typedef logic [CFG_IDX_W-1:0]     cfg_idx_t;

	typedef enum logic [1:0] {
		OP_FORCE    = 2'd0,
		OP_STEP     = 2'd1,
		OP_LOAD_POS = 2'd2,
		OP_LOAD_VEL = 2'd3
	} op_t;

	localparam cfg_idx_t REG_INV_MASS = cfg_idx_t'(0);
	localparam cfg_idx_t REG_ACCEL_X  = cfg_idx_t'(1);
	localparam cfg_idx_t REG_ACCEL_Y  = cfg_idx_t'(2);
	localparam cfg_idx_t REG_ACCEL_Z  = cfg_idx_t'(3);

	localparam uq16_t INV_MASS_RST = 32'h0001_0000;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL1,
		ST_MUL2,
		ST_MUL3,
		ST_COMMIT
	} state_t;

	typedef struct packed {
		logic commit;
		op_t  op;
	} lane_ctl_t;

	// Clamp a wide signed value to the 32-bit signed range.
	function automatic q16_t sat32(input logic signed [63:0] x);
		logic signed [63:0] hi;
		logic signed [63:0] lo;
		hi = 64'sh0000_0000_7FFF_FFFF;
		lo = -64'sh0000_0000_8000_0000;
		if (x > hi) begin
			return q16_t'(hi);
		end else if (x < lo) begin
			return q16_t'(lo);
		end
		return q16_t'(x);
	endfunction

endpackage

### sv/pmi_if.sv
// Handshake interfaces of the particle motion integrator: input, result and configuration.
interface pmi_in_if;
	logic            valid;
	logic            ready;
	pmi_pkg::op_t    op;
	pmi_pkg::q16_t   vec_x;
	pmi_pkg::q16_t   vec_y;
	pmi_pkg::q16_t   vec_z;
	pmi_pkg::dt_t    dt;

	modport source (output valid, op, vec_x, vec_y, vec_z, dt, input ready);
	modport sink   (input valid, op, vec_x, vec_y, vec_z, dt, output ready);
endinterface

interface pmi_out_if;
	logic            valid;
	logic            ready;
	pmi_pkg::q16_t   pos_x;
	pmi_pkg::q16_t   pos_y;
	pmi_pkg::q16_t   pos_z;
	pmi_pkg::q16_t   vel_x;
	pmi_pkg::q16_t   vel_y;
	pmi_pkg::q16_t   vel_z;

	modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, input ready);
	modport sink   (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z, output ready);
endinterface

interface pmi_cfg_if;
	logic              valid;
	logic              ready;
	pmi_pkg::cfg_idx_t index;
	pmi_pkg::uq16_t    data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

### sv/pmi_ctrl.sv
// Sequencer of the integrator: item acceptance, multiply stages, commit and result valid.
module pmi_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  pmi_pkg::op_t       in_op,
	input  logic               out_ready,
	output logic               in_ready,
	output logic               accept,
	output pmi_pkg::lane_ctl_t ctl,
	output logic               out_valid
);
	import pmi_pkg::*;

	state_t state_q;
	state_t state_nxt;
	op_t    op_q;
	logic   out_valid_q;
	logic   commit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_FORCE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				op_q <= in_op;
			end
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		in_ready  = 1'b0;
		commit    = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_nxt = (in_op == OP_STEP) ? ST_MUL1 : ST_COMMIT;
				end
			end
			ST_MUL1: state_nxt = ST_MUL2;
			ST_MUL2: state_nxt = ST_MUL3;
			ST_MUL3: state_nxt = ST_COMMIT;
			ST_COMMIT: begin
				// The new result may only land once the output register is free.
				if (!out_valid_q || out_ready) begin
					commit    = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign accept     = in_valid && in_ready;
	assign ctl.commit = commit;
	assign ctl.op     = op_q;
	assign out_valid  = out_valid_q;

endmodule

### sv/pmi_lane.sv
// One axis of the integrator: position, velocity and force state with the step datapath.
module pmi_lane (
	input  logic               clk,
	input  logic               arst_n,
	input  pmi_pkg::lane_ctl_t ctl,
	input  pmi_pkg::q16_t      vec,
	input  pmi_pkg::dt_t       dt,
	input  pmi_pkg::uq16_t     inv_mass,
	input  pmi_pkg::q16_t      accel,
	output pmi_pkg::q16_t      pos_nxt,
	output pmi_pkg::q16_t      vel_nxt
);
	import pmi_pkg::*;

	q16_t pos_q;
	q16_t vel_q;
	q16_t force_q;
	q16_t force_nxt;

	logic signed [47:0] vdt_s1;
	logic signed [63:0] fim_s1;
	logic [31:0]        dd_s1;
	logic signed [63:0] ad2_s2;
	logic signed [48:0] acc_s2;
	logic signed [64:0] adt_s3;
	q16_t               pos_s3;

	logic signed [63:0] move_sum;
	logic signed [63:0] vel_sum;

	// Stage one: velocity times dt, force times inverse mass, dt squared.
	// Stage two: acceleration times dt squared, total acceleration.
	// Stage three: total acceleration times dt, new position.
	// The operands hold still for the whole step as long as configuration writes keep to idle, so the stages run freely.
	always_ff @(posedge clk) begin
		vdt_s1 <= 48'(vel_q * $signed({1'b0, dt}));
		fim_s1 <= 64'(force_q * $signed({1'b0, inv_mass}));
		dd_s1  <= {16'd0, dt} * {16'd0, dt};
		ad2_s2 <= 64'(accel * $signed({1'b0, dd_s1}));
		acc_s2 <= 49'(accel) + 49'(fim_s1 >>> 16);
		adt_s3 <= 65'(acc_s2 * $signed({1'b0, dt}));
		pos_s3 <= sat32(move_sum);
	end

	assign move_sum = 64'(pos_q) + 64'(vdt_s1 >>> 16) + (ad2_s2 >>> 33);
	assign vel_sum  = 64'(vel_q) + 64'(adt_s3 >>> 16);

	always_comb begin
		pos_nxt   = pos_q;
		vel_nxt   = vel_q;
		force_nxt = force_q;
		case (ctl.op)
			OP_FORCE:    force_nxt = sat32(64'(force_q) + 64'(vec));
			OP_STEP: begin
				pos_nxt   = pos_s3;
				vel_nxt   = sat32(vel_sum);
				force_nxt = '0;
			end
			OP_LOAD_POS: pos_nxt = vec;
			OP_LOAD_VEL: vel_nxt = vec;
			default:     force_nxt = force_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q   <= '0;
			vel_q   <= '0;
			force_q <= '0;
		end else if (ctl.commit) begin
			pos_q   <= pos_nxt;
			vel_q   <= vel_nxt;
			force_q <= force_nxt;
		end
	end

endmodule

### sv/particle_motion_integrator.sv
// Top level of the particle motion integrator: three axis lanes, sequencer and result register.
// Results: an integrate item passes through the three chained multiply stages of each lane
// before it commits, other items commit directly, and a commit waits while an earlier result
// is not taken. One item is in flight at a time: the next is accepted once the last commits.
// Reset: position, velocity, force and acceleration clear, inverse mass returns to 1.0,
// and the block is ready for items as soon as reset is released.
module particle_motion_integrator (
	input  logic       clk,
	input  logic       arst_n,
	pmi_in_if.sink     in_ch,
	pmi_out_if.source  out_ch,
	pmi_cfg_if.sink    cfg_ch
);
	import pmi_pkg::*;

	// Configuration registers. Writes are to arrive only while the block is idle; the
	// user is bound to this, the block itself does not enforce it. Writes are always taken.
	uq16_t inv_mass_q;
	q16_t  accel_q [AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inv_mass_q <= INV_MASS_RST;
			for (int i = 0; i < AXES; i++) begin
				accel_q[i] <= '0;
			end
		end else if (cfg_ch.valid) begin
			// Indexes beyond the register list are dropped.
			if (cfg_ch.index == REG_INV_MASS) begin
				inv_mass_q <= cfg_ch.data;
			end
			if (cfg_ch.index == REG_ACCEL_X) begin
				accel_q[0] <= q16_t'(cfg_ch.data);
			end
			if (cfg_ch.index == REG_ACCEL_Y) begin
				accel_q[1] <= q16_t'(cfg_ch.data);
			end
			if (cfg_ch.index == REG_ACCEL_Z) begin
				accel_q[2] <= q16_t'(cfg_ch.data);
			end
		end
	end

	assign cfg_ch.ready = 1'b1;

	// The sequencer takes one item at a time, steps the lanes through their multiply
	// stages for an integrate item, and then commits the new state.
	logic      accept;
	logic      in_ready;
	logic      out_valid;
	lane_ctl_t ctl;

	pmi_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_op     (in_ch.op),
		.out_ready (out_ch.ready),
		.in_ready  (in_ready),
		.accept    (accept),
		.ctl       (ctl),
		.out_valid (out_valid)
	);

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

	// The item's operands are held for the lanes while the item is in flight.
	q16_t vec_q [AXES];
	dt_t  dt_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			vec_q[0] <= in_ch.vec_x;
			vec_q[1] <= in_ch.vec_y;
			vec_q[2] <= in_ch.vec_z;
			dt_q     <= in_ch.dt;
		end
	end

	// One lane for each axis, all running in lockstep.
	q16_t pos_nxt [AXES];
	q16_t vel_nxt [AXES];

	for (genvar g = 0; g < AXES; g++) begin : g_lane
		pmi_lane u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.vec      (vec_q[g]),
			.dt       (dt_q),
			.inv_mass (inv_mass_q),
			.accel    (accel_q[g]),
			.pos_nxt  (pos_nxt[g]),
			.vel_nxt  (vel_nxt[g])
		);
	end

	// The result register gathers the lanes' new state at commit. It parts
	// the result side from the input side, so a new item is accepted while
	// an earlier result still waits to be taken.
	q16_t pos_q [AXES];
	q16_t vel_q [AXES];

	always_ff @(posedge clk) begin
		if (ctl.commit) begin
			for (int i = 0; i < AXES; i++) begin
				pos_q[i] <= pos_nxt[i];
				vel_q[i] <= vel_nxt[i];
			end
		end
	end

	assign out_ch.pos_x = pos_q[0];
	assign out_ch.pos_y = pos_q[1];
	assign out_ch.pos_z = pos_q[2];
	assign out_ch.vel_x = vel_q[0];
	assign out_ch.vel_y = vel_q[1];
	assign out_ch.vel_z = vel_q[2];

endmodule

### sv/pmi_checker.sv
// Port-level assertions of the particle motion integrator and the bind that attaches them.
module pmi_checker (
	input logic          clk,
	input logic          arst_n,
	input logic          in_valid,
	input logic          in_ready,
	input pmi_pkg::op_t  in_op,
	input pmi_pkg::q16_t in_vec_x,
	input pmi_pkg::q16_t in_vec_y,
	input logic          out_valid,
	input logic          out_ready,
	input pmi_pkg::q16_t out_pos_x,
	input pmi_pkg::q16_t out_vel_y
);
	import pmi_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// A result waiting on the output side stays offered until taken.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before it was taken");

	// Only one item is in flight: the input closes right after an acceptance.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> !in_ready)
		else $error("second item accepted while one is in flight");

	// A new result appears only after the input side was closed for the commit.
	a_rise_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without an item in flight");

	// With the output free, a loaded position passes the operand and result registers and comes back.
	a_load_pos: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_op == OP_LOAD_POS && !out_valid |=> ##1
		(out_valid && out_pos_x == $past(in_vec_x, 2)))
		else $error("loaded position not returned");

	// Likewise for a loaded velocity.
	a_load_vel: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_op == OP_LOAD_VEL && !out_valid |=> ##1
		(out_valid && out_vel_y == $past(in_vec_y, 2)))
		else $error("loaded velocity not returned");

endmodule

bind particle_motion_integrator pmi_checker u_pmi_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_op     (in_ch.op),
	.in_vec_x  (in_ch.vec_x),
	.in_vec_y  (in_ch.vec_y),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_pos_x (out_ch.pos_x),
	.out_vel_y (out_ch.vel_y)
);
